FILE: sv/oeb_pkg.sv
// oeb_pkg: shared sizes, command codes and item types for the oldest-evict buffer
// no dependencies; used by oldest_evict_buffer

package oeb_pkg;

    localparam int ENTRIES    = 3;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int STAMP_W    = 32;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [STAMP_W-1:0]    t_stamp;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [ENTRIES-1:0]    t_mask;

    typedef struct packed {
        logic        cmd;
        logic [31:0] data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  slot;
        logic        evicted;
        logic [31:0] evicted_data;
    } t_result;

endpackage

FILE: sv/oldest_evict_buffer.sv
// oldest_evict_buffer: small replacement table that evicts its oldest entry when full
// depends on oeb_pkg (sizes, command codes, item structs)
// an accepted item is held in the input register, and its result is strobed from the result register
// throughput: one item per cycle; busy is never raised, the table and stamp compares are
// evaluated in full, combinationally, between the input register and the result register
// reset (synchronous, active low) empties every slot and zeroes the stamp counter
// the receiver cannot stall: each result is shown for one cycle with o_strobe high

module oldest_evict_buffer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  oeb_pkg::t_in_item i_item,
    output logic              o_strobe,
    output oeb_pkg::t_result  o_result
);

    // input register stage
    logic              r_in_valid;
    oeb_pkg::t_in_item r_in;

    // table state
    oeb_pkg::t_mask  r_valid;
    oeb_pkg::t_stamp r_stamp [oeb_pkg::ENTRIES];
    oeb_pkg::t_data  r_data  [oeb_pkg::ENTRIES];
    oeb_pkg::t_stamp r_counter;

    // result register
    logic             r_strobe;
    oeb_pkg::t_result r_result;

    // next values and search results
    oeb_pkg::t_mask   n_valid;
    oeb_pkg::t_stamp  n_counter;
    oeb_pkg::t_result n_result;
    logic             full;
    oeb_pkg::t_mask   empty_mask;
    oeb_pkg::t_mask   first_empty_oh;
    oeb_pkg::t_mask   old_oh;
    oeb_pkg::t_mask   tgt_oh;
    oeb_pkg::t_idx    tgt_idx;
    oeb_pkg::t_data   victim_data;
    logic             do_add;
    logic             do_clear;

    // never holds off the sender: a new item fits in every cycle
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        if (start && !busy) begin
            r_in <= i_item;
        end
    end

    assign do_add   = r_in_valid && (r_in.cmd == oeb_pkg::CMD_ADD);
    assign do_clear = r_in_valid && (r_in.cmd == oeb_pkg::CMD_CLEAR);

    // full check and lowest empty slot (isolate lowest set bit)
    assign full           = &r_valid;
    assign empty_mask     = ~r_valid;
    assign first_empty_oh = empty_mask & (~empty_mask + oeb_pkg::t_mask'(1));

    // oldest search as a compare matrix: slot i wins if it is strictly older than every
    // lower slot and no younger than every higher slot, so ties go to the lowest index
    always_comb begin
        old_oh = '0;
        for (int i = 0; i < oeb_pkg::ENTRIES; i++) begin
            old_oh[i] = 1'b1;
            for (int j = 0; j < oeb_pkg::ENTRIES; j++) begin
                if (j < i) begin
                    old_oh[i] = old_oh[i] && (r_stamp[i] < r_stamp[j]);
                end else if (j > i) begin
                    old_oh[i] = old_oh[i] && (r_stamp[i] <= r_stamp[j]);
                end
            end
        end
    end

    // when full the freed slot is the only empty one, so it is also the target
    assign tgt_oh = full ? old_oh : first_empty_oh;

    // one-hot to index, and victim data through a one-hot mux
    always_comb begin
        tgt_idx     = '0;
        victim_data = '0;
        for (int i = 0; i < oeb_pkg::ENTRIES; i++) begin
            if (tgt_oh[i]) begin
                tgt_idx = tgt_idx | oeb_pkg::t_idx'(i);
            end
            if (old_oh[i]) begin
                victim_data = victim_data | r_data[i];
            end
        end
    end

    always_comb begin
        n_valid   = r_valid;
        n_counter = r_counter;
        n_result  = r_result;
        if (do_clear) begin
            n_valid  = '0;
            n_result = '0;
        end else if (do_add) begin
            n_valid                = r_valid | tgt_oh;
            n_counter              = r_counter + oeb_pkg::t_stamp'(1);
            n_result.slot          = 2'(tgt_idx);
            n_result.evicted       = full;
            n_result.evicted_data  = full ? 32'(victim_data) : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_counter <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_counter <= n_counter;
            r_strobe  <= r_in_valid;
        end
        r_result <= n_result;
    end

    // stamp and data write for the chosen slot; a clear only drops the valid marks
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < oeb_pkg::ENTRIES; i++) begin
            if (do_add && tgt_oh[i]) begin
                r_stamp[i] <= n_counter;
                r_data[i]  <= oeb_pkg::t_data'(r_in.data);
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // an add into a full table must report an eviction
    a_full_evicts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_add && full |=> o_strobe && o_result.evicted)
        else $error("add into full table did not evict");

    // exactly one oldest slot whenever eviction can happen
    a_one_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && full |-> $onehot(old_oh))
        else $error("oldest search not one-hot");

    // no eviction means no victim data
    a_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.evicted |-> o_result.evicted_data == 32'd0)
        else $error("victim data without eviction");

    // clear empties the table
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_clear |=> r_valid == '0)
        else $error("clear left valid slots");

    // each add advances the stamp counter by one
    a_stamp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_add |=> r_counter == $past(r_counter) + oeb_pkg::t_stamp'(1))
        else $error("stamp counter did not step");

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for oldest_evict_buffer, fill, eviction, clear and random traffic
// depends on oeb_pkg (sizes, command codes, item structs) and the oldest_evict_buffer rtl
// a table predictor works out every result, and each strobed result is checked against it

module tb;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    oeb_pkg::t_in_item i_item;
    logic              o_strobe;
    oeb_pkg::t_result  o_result;

    // predicted table contents, kept in step with every accepted item
    oeb_pkg::t_mask    tbl_valid;
    oeb_pkg::t_stamp   tbl_stamp [oeb_pkg::ENTRIES];
    oeb_pkg::t_data    tbl_data  [oeb_pkg::ENTRIES];
    oeb_pkg::t_stamp   tbl_counter;

    oeb_pkg::t_result  pending_results [$];
    int                mismatch_count;
    bit                no_gaps;
    int                items_sent;

    oldest_evict_buffer i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 10 unit clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // table behaviour: a clear empties everything but keeps the stamp counter,
    // an add takes the lowest empty slot, evicting the smallest stamp when full
    function automatic oeb_pkg::t_result predict_table_result(input oeb_pkg::t_in_item it);
        oeb_pkg::t_result res;
        int               oldest;
        int               target;
        res = '0;
        if (it.cmd == oeb_pkg::CMD_CLEAR) begin
            for (int i = 0; i < oeb_pkg::ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_stamp[i] = '0;
                tbl_data[i]  = '0;
            end
            return res;
        end
        if (&tbl_valid) begin
            // ties go to the lowest index, hence the strict compare
            oldest = 0;
            for (int i = 1; i < oeb_pkg::ENTRIES; i++) begin
                if (tbl_stamp[i] < tbl_stamp[oldest])
                    oldest = i;
            end
            res.evicted      = 1'b1;
            res.evicted_data = 32'(tbl_data[oldest]);
            tbl_valid[oldest] = 1'b0;
            tbl_stamp[oldest] = '0;
            tbl_data[oldest]  = '0;
        end
        target = 0;
        for (int i = oeb_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (!tbl_valid[i])
                target = i;
        end
        tbl_counter       = tbl_counter + 1'b1;
        tbl_valid[target] = 1'b1;
        tbl_stamp[target] = tbl_counter;
        tbl_data[target]  = oeb_pkg::t_data'(it.data);
        res.slot = 2'(target);
        return res;
    endfunction

    // drives one item, with random idle cycles first unless gaps are off;
    // the expectation is queued at the edge that accepts the item
    task automatic send_item(input logic cmd, input logic [31:0] data);
        oeb_pkg::t_in_item it;
        it.cmd  = cmd;
        it.data = data;
        if (!no_gaps) begin
            while ($urandom_range(99) < 29) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(predict_table_result(it));
        items_sent++;
    endtask

    // random data word, with the all-zero and all-one extremes now and then
    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return 32'h0000_0000;
        if (pick == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // result checker: every strobe must match the oldest pending expectation
    always @(posedge i_clk) begin
        oeb_pkg::t_result exp_res;
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_result);
                    mismatch_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (o_result.slot !== exp_res.slot) begin
                        $display("%0t: slot mismatch, expected %0d, actual %0d",
                                 $time, exp_res.slot, o_result.slot);
                        mismatch_count++;
                    end
                    if (o_result.evicted !== exp_res.evicted) begin
                        $display("%0t: evicted mismatch, expected %0b, actual %0b",
                                 $time, exp_res.evicted, o_result.evicted);
                        mismatch_count++;
                    end
                    if (o_result.evicted_data !== exp_res.evicted_data) begin
                        $display("%0t: evicted_data mismatch, expected %h, actual %h",
                                 $time, exp_res.evicted_data, o_result.evicted_data);
                        mismatch_count++;
                    end
                end
            end else if (o_strobe !== 1'b0) begin
                $display("%0t: strobe unknown, expected 0 or 1, actual %b", $time, o_strobe);
                mismatch_count++;
            end
        end
    end

    // first adds after reset: table fills from slot 0 upwards, no eviction yet,
    // data extremes go in here so they come back out on eviction later
    task automatic test_fill_from_reset();
        send_item(oeb_pkg::CMD_ADD, 32'h0000_0000);
        send_item(oeb_pkg::CMD_ADD, 32'hFFFF_FFFF);
        send_item(oeb_pkg::CMD_ADD, 32'hA5A5_A5A5);
    endtask

    // full table: each add evicts the oldest stamp, so the slots cycle 0, 1, 2, 0
    task automatic test_evict_oldest();
        send_item(oeb_pkg::CMD_ADD, 32'h5A5A_5A5A);
        send_item(oeb_pkg::CMD_ADD, 32'h0000_0001);
        send_item(oeb_pkg::CMD_ADD, 32'h8000_0000);
        send_item(oeb_pkg::CMD_ADD, 32'h7FFF_FFFF);
    endtask

    // clear on a full, a partly filled and an empty table; the data word of a
    // clear is ignored, and the counter keeps running across clears
    task automatic test_clear();
        send_item(oeb_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
        send_item(oeb_pkg::CMD_ADD, 32'h1234_5678);
        send_item(oeb_pkg::CMD_CLEAR, 32'h0000_0000);
        send_item(oeb_pkg::CMD_CLEAR, 32'hDEAD_BEEF);
        send_item(oeb_pkg::CMD_ADD, 32'hFFFF_FFFF);
        send_item(oeb_pkg::CMD_ADD, 32'h0000_0000);
        send_item(oeb_pkg::CMD_CLEAR, 32'h5555_5555);
        for (int i = 0; i < 5; i++)
            send_item(oeb_pkg::CMD_ADD, rand_word());
    endtask

    // sender holds off until every outstanding result has come back
    task automatic test_drain_pause();
        for (int i = 0; i < 4; i++)
            send_item(oeb_pkg::CMD_ADD, rand_word());
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        for (int i = 0; i < 4; i++)
            send_item(oeb_pkg::CMD_ADD, rand_word());
    endtask

    // random traffic: mostly adds so the table fills and evicts often, with a
    // clear about one item in ten; the first stretch runs back to back
    task automatic test_random_traffic(input int count);
        logic cmd;
        for (int i = 0; i < count; i++) begin
            no_gaps = (i < count / 3);
            cmd = ($urandom_range(99) < 10) ? oeb_pkg::CMD_CLEAR : oeb_pkg::CMD_ADD;
            send_item(cmd, rand_word());
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        mismatch_count = 0;
        items_sent     = 0;
        no_gaps        = 1'b0;
        tbl_valid      = '0;
        tbl_counter    = '0;
        for (int i = 0; i < oeb_pkg::ENTRIES; i++) begin
            tbl_stamp[i] = '0;
            tbl_data[i]  = '0;
        end
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_from_reset();
        test_evict_oldest();
        test_clear();
        test_drain_pause();
        test_random_traffic(2000);

        // wait for the last results, then keep watching for any stray strobe
        start <= 1'b0;
        for (int n = 0; n < 200 && pending_results.size() != 0; n++)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, pending_results.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
sv/oeb_pkg.sv
sv/oldest_evict_buffer.sv
bench/tb.sv
